// ===== sv/sld_pkg.sv =====
// sld_pkg: constants, types and helper functions for the servo/LED command decoder.
// No dependencies; used by sld_in_reg, sld_exec, sld_out_reg and the top level.
package sld_pkg;

    // Command framing
    localparam int unsigned CmdLen    = 5;
    localparam int unsigned NumServos = 3;
    localparam int unsigned PosWidth  = 3;

    // Character codes
    localparam logic [7:0] ChrS     = 8'h53;   // 'S'
    localparam logic [7:0] ChrL     = 8'h4C;   // 'L'
    localparam logic [7:0] ChrO     = 8'h4F;   // 'O'
    localparam logic [7:0] ChrF     = 8'h46;   // 'F'
    localparam logic [7:0] ChrN     = 8'h4E;   // 'N'
    localparam logic [7:0] ChrPlus  = 8'h2B;   // '+'
    localparam logic [7:0] ChrMinus = 8'h2D;   // '-'
    localparam logic [7:0] ChrZero  = 8'h30;   // '0'
    localparam logic [7:0] ChrOne   = 8'h31;   // '1'
    localparam logic [7:0] ChrTwo   = 8'h32;   // '2'
    localparam logic [7:0] ChrNine  = 8'h39;   // '9'
    localparam logic [7:0] ChrSpace = 8'h20;
    localparam logic [7:0] ChrTab   = 8'h09;
    localparam logic [7:0] ChrCr    = 8'h0D;

    // Compare value arithmetic: 100*base/9 - 1, base = 270 +/- angle
    localparam int unsigned CmpWidth     = 12;
    localparam logic [11:0] ResetCompare = 12'd2999;
    localparam logic [8:0]  AngleBase    = 9'd270;
    // floor(100*base/9) = (base * 5825500) >> 19, exact for base <= 360
    localparam logic [22:0] RecipScaled  = 23'd5825500;
    localparam int unsigned RecipShift   = 19;

    // Status codes
    localparam logic StatusAck     = 1'b0;
    localparam logic StatusInvalid = 1'b1;

    // Byte held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_stage_t;

    // Handshake between the execute stage and its neighbours
    typedef struct packed {
        logic consume;   // held byte leaves the input register this cycle
        logic load;      // a result is written to the output register
    } exec_ctl_t;

    // One result item
    typedef struct packed {
        logic        status;
        logic [11:0] servo0_compare;
        logic [11:0] servo1_compare;
        logic [11:0] servo2_compare;
        logic [1:0]  led_bits;
    } result_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == ChrSpace) || ((b >= ChrTab) && (b <= ChrCr));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= ChrZero) && (b <= ChrNine);
    endfunction

endpackage

// ===== sv/sld_rx_if.sv =====
// sld_rx_if: receive byte channel, valid/ready handshake.
// No dependencies.
interface sld_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== sv/sld_res_if.sv =====
// sld_res_if: result channel carrying status, compare values and LED bits.
// No dependencies.
interface sld_res_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [11:0] servo0_compare;
    logic [11:0] servo1_compare;
    logic [11:0] servo2_compare;
    logic [1:0]  led_bits;

    modport source (output valid, output status, output servo0_compare,
                    output servo1_compare, output servo2_compare,
                    output led_bits, input ready);
    modport sink   (input valid, input status, input servo0_compare,
                    input servo1_compare, input servo2_compare,
                    input led_bits, output ready);
endinterface

// ===== sv/sld_in_reg.sv =====
// sld_in_reg: input register for received bytes.
// Depends on sld_pkg and sld_rx_if.
module sld_in_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    sld_rx_if.sink               rx,
    input  sld_pkg::exec_ctl_t   ctl,
    output sld_pkg::byte_stage_t stage
);

    logic       valid_reg;
    logic [7:0] data_reg;

    // Free when empty or when the held byte leaves this cycle
    assign rx.ready = !valid_reg || ctl.consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctl.consume)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            data_reg <= rx.rx_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

// ===== sv/sld_exec.sv =====
// sld_exec: command framing, decode and state update (compare values, LEDs).
// Depends on sld_pkg.
module sld_exec
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sld_pkg::byte_stage_t stage,
    input  logic                 res_free,
    output sld_pkg::exec_ctl_t   ctl,
    output sld_pkg::result_t     result
);

    logic [sld_pkg::PosWidth-1:0] pos_reg;
    logic [sld_pkg::PosWidth-1:0] pos_next;
    logic [7:0]                   held_reg [4];
    logic [11:0]                  cmp_reg  [sld_pkg::NumServos];
    logic [11:0]                  cmp_next [sld_pkg::NumServos];
    logic [1:0]                   led_reg;
    logic [1:0]                   led_next;

    logic        last_byte;
    logic        skip;
    logic        consume;
    logic        load;
    logic [7:0]  b0, b1, b2, b3, b4;
    logic        servo_ok;
    logic        led_ok;
    logic [6:0]  mag;
    logic [8:0]  base;
    logic [31:0] prod;
    logic [12:0] quot;
    logic [11:0] new_cmp;
    logic [1:0]  chan;

    // Framing
    assign last_byte = (pos_reg == 3'(sld_pkg::CmdLen - 1));
    assign skip      = (pos_reg == '0) && sld_pkg::is_blank(stage.data);
    assign consume   = stage.valid && (!last_byte || res_free);
    assign load      = consume && last_byte;
    assign ctl.consume = consume;
    assign ctl.load    = load;

    always_comb
    begin
        pos_next = pos_reg;
        if (consume && !skip)
        begin
            pos_next = last_byte ? '0 : pos_reg + 3'd1;
        end
    end

    // Command bytes
    assign b0 = held_reg[0];
    assign b1 = held_reg[1];
    assign b2 = held_reg[2];
    assign b3 = held_reg[3];
    assign b4 = stage.data;

    // Servo command check and compare value
    assign servo_ok = (b0 == sld_pkg::ChrS) && (b1 >= sld_pkg::ChrZero)
                   && (b1 <= sld_pkg::ChrTwo)
                   && ((b2 == sld_pkg::ChrPlus) || (b2 == sld_pkg::ChrMinus))
                   && sld_pkg::is_digit(b3) && sld_pkg::is_digit(b4)
                   && ((b3 < sld_pkg::ChrNine) || (b4 == sld_pkg::ChrZero));
    assign mag  = {b3[3:0], 3'b000} + {2'b00, b3[3:0], 1'b0} + {3'b000, b4[3:0]};
    assign base = (b2 == sld_pkg::ChrMinus) ? (sld_pkg::AngleBase - {2'b00, mag})
                                            : (sld_pkg::AngleBase + {2'b00, mag});
    assign prod    = 32'(base) * 32'(sld_pkg::RecipScaled);
    assign quot    = prod[sld_pkg::RecipShift +: 13];
    assign new_cmp = 12'(quot - 13'd1);
    assign chan    = b1[1:0];

    // LED command check
    assign led_ok = (b0 == sld_pkg::ChrL)
                 && ((b1 == sld_pkg::ChrZero) || (b1 == sld_pkg::ChrOne))
                 && (b2 == sld_pkg::ChrO) && (b3 == b4)
                 && ((b4 == sld_pkg::ChrF) || (b4 == sld_pkg::ChrN));

    // Next state of the outputs-visible registers
    always_comb
    begin
        for (int i = 0; i < sld_pkg::NumServos; i++)
        begin
            cmp_next[i] = cmp_reg[i];
            if (load && servo_ok && (chan == 2'(i)))
            begin
                cmp_next[i] = new_cmp;
            end
        end
        led_next = led_reg;
        if (load && led_ok)
        begin
            led_next[b1[0]] = (b4 == sld_pkg::ChrN);
        end
    end

    assign result.status = (servo_ok || led_ok) ? sld_pkg::StatusAck
                                                : sld_pkg::StatusInvalid;
    assign result.servo0_compare = cmp_next[0];
    assign result.servo1_compare = cmp_next[1];
    assign result.servo2_compare = cmp_next[2];
    assign result.led_bits       = led_next;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            led_reg <= '0;
            for (int i = 0; i < sld_pkg::NumServos; i++)
            begin
                cmp_reg[i] <= sld_pkg::ResetCompare;
            end
        end
        else
        begin
            pos_reg <= pos_next;
            led_reg <= led_next;
            for (int i = 0; i < sld_pkg::NumServos; i++)
            begin
                cmp_reg[i] <= cmp_next[i];
            end
        end
    end

    // Held command bytes, written before they are read
    always_ff @(posedge clk)
    begin
        if (consume && !skip && !last_byte)
        begin
            held_reg[pos_reg[1:0]] <= stage.data;
        end
    end

endmodule

// ===== sv/sld_out_reg.sv =====
// sld_out_reg: result register driving the result channel.
// Depends on sld_pkg and sld_res_if.
module sld_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  sld_pkg::exec_ctl_t ctl,
    input  sld_pkg::result_t   result,
    output logic               res_free,
    sld_res_if.source          res
);

    logic             valid_reg;
    sld_pkg::result_t data_reg;

    // Slot free when empty or being taken this cycle
    assign res_free = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            data_reg <= result;
        end
    end

    assign res.valid          = valid_reg;
    assign res.status         = data_reg.status;
    assign res.servo0_compare = data_reg.servo0_compare;
    assign res.servo1_compare = data_reg.servo1_compare;
    assign res.servo2_compare = data_reg.servo2_compare;
    assign res.led_bits       = data_reg.led_bits;

endmodule

// ===== sv/servo_led_command_decoder_unit.sv =====
// servo_led_command_decoder_unit: top level of the servo/LED command decoder.
// Depends on sld_pkg, sld_rx_if, sld_res_if, sld_in_reg, sld_exec, sld_out_reg.
//
// Usage:
//   rx  : one ASCII byte per transfer. Blanks are dropped before a command;
//         the next five bytes form the command.
//   res : one transfer per command, on its fifth byte: status (0 ack,
//         1 invalid) and the three servo compare values and LED bits as they
//         stand after the command.
//   Path: a byte is registered at the input register, then decoded, and the
//   result is registered in the result register, from which it is offered.
//   Throughput: one byte per cycle except while a fifth byte waits for the result
//   register, set by the single decode stage between the input and result registers.
//   Reset: compare values return to 2999 (zero degrees), LEDs off, framing
//   restarts at the first byte; both registers are emptied.
//   Stall: while a result waits, bytes that complete no command keep flowing;
//   the fifth byte of the next command waits in the input register until the
//   result register is taken.
module servo_led_command_decoder_unit
(
    input  logic      clk,
    input  logic      rst_n,
    sld_rx_if.sink    rx,
    sld_res_if.source res
);

    sld_pkg::byte_stage_t stage;
    sld_pkg::exec_ctl_t   ctl;
    sld_pkg::result_t     result;
    logic                 res_free;

    sld_in_reg u_in_reg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .ctl   (ctl),
        .stage (stage)
    );

    sld_exec u_exec
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage    (stage),
        .res_free (res_free),
        .ctl      (ctl),
        .result   (result)
    );

    sld_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .result   (result),
        .res_free (res_free),
        .res      (res)
    );

    // A result is never written over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n) ctl.load |-> res_free)
        else $error("result register overwritten");

    // Only a held byte can be consumed
    assert property (@(posedge clk) disable iff (!rst_n) ctl.consume |-> stage.valid)
        else $error("consume without a held byte");

    // Compare values stay inside the servo range
    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.servo0_compare >= 12'd1999) && (res.servo0_compare <= 12'd3999)
                   && (res.servo1_compare >= 12'd1999) && (res.servo1_compare <= 12'd3999)
                   && (res.servo2_compare >= 12'd1999) && (res.servo2_compare <= 12'd3999))
        else $error("compare value out of range");

endmodule
